// ===== sv/htbd_pkg.sv =====
// Shared types and constants for the hex text to byte decoder.
// No dependencies; used by the top level, the front end and the back end.
package htbd_pkg;

    // Default queue depths (entries)
    localparam int TOKEN_DEPTH_DEFAULT  = 2;
    localparam int RESULT_DEPTH_DEFAULT = 2;

    // Character codes of interest
    localparam logic [7:0] CHAR_SLASH      = 8'h2F;
    localparam logic [7:0] CHAR_STAR       = 8'h2A;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_LF         = 8'h0A;
    localparam logic [7:0] CHAR_CR         = 8'h0D;
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_TAB        = 8'h09;
    localparam logic [7:0] CHAR_VT         = 8'h0B;
    localparam logic [7:0] CHAR_FF         = 8'h0C;

    // Input op codes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Character class found by the front end
    typedef enum logic [2:0] {
        CLS_END   = 3'd0,
        CLS_DIGIT = 3'd1,
        CLS_EOL   = 3'd2,
        CLS_SPACE = 3'd3,
        CLS_SLASH = 3'd4,
        CLS_STAR  = 3'd5,
        CLS_OTHER = 3'd6
    } cls_t;

    typedef struct packed {
        cls_t       cls;
        logic [3:0] digit;
    } token_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_STOP  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } result_t;

    // Parser status seen by the top level checks
    typedef struct packed {
        logic at_start;   // normal text, no first digit held
        logic have_high;  // first digit held
    } status_t;

endpackage

// ===== sv/hex_text_to_byte_decoder_top.sv =====
// Top level of the hex text to byte decoder: front end, token queue, back end,
// result queue. Depends on htbd_pkg, htbd_front, htbd_fifo, htbd_back.
//
//  channel   ports                              handshake
//  -------   ---------------------------------  ---------------------------
//  input     op, char_code                      push / full
//  result    kind, data_byte                    empty / pop
//  config    cfg_write_data                     cfg_write_en, no wait
//
// One character per cycle sustained while the result queue has room; a result
// reaches the result ports by way of the token queue, which holds its token, and
// the result queue, which the back end writes.
// Reset (rst_n low) empties both queues, clears the underscore option and
// returns the parser to normal text. A full result queue stalls the back end
// only; the token queue keeps taking input until it fills.
module hex_text_to_byte_decoder_top #(
    parameter int TOKEN_DEPTH  = htbd_pkg::TOKEN_DEPTH_DEFAULT,
    parameter int RESULT_DEPTH = htbd_pkg::RESULT_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic       cfg_write_data,
    input  logic       push,
    output logic       full,
    input  logic       op,
    input  logic [7:0] char_code,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] kind,
    output logic [7:0] data_byte
);

    htbd_pkg::token_t  in_token;
    htbd_pkg::token_t  q_token;
    logic              tok_empty;
    logic              tok_take;
    logic              res_full;
    logic              res_push;
    htbd_pkg::result_t res_in;
    htbd_pkg::result_t res_out;
    htbd_pkg::status_t status;

    // Classify
    htbd_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .op             (op),
        .char_code      (char_code),
        .token          (in_token)
    );

    // Token queue between front and back
    htbd_fifo #(
        .DEPTH (TOKEN_DEPTH),
        .WIDTH ($bits(htbd_pkg::token_t))
    ) u_tok_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .data_in  (in_token),
        .pop      (tok_take),
        .empty    (tok_empty),
        .data_out (q_token)
    );

    // Parse
    htbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (!tok_empty),
        .tok       (q_token),
        .tok_take  (tok_take),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in),
        .status    (status)
    );

    // Result queue
    htbd_fifo #(
        .DEPTH (RESULT_DEPTH),
        .WIDTH ($bits(htbd_pkg::result_t))
    ) u_res_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_push),
        .full     (res_full),
        .data_in  (res_in),
        .pop      (pop),
        .empty    (empty),
        .data_out (res_out)
    );

    assign kind      = res_out.kind;
    assign data_byte = res_out.data;

    // End of text always leaves the parser at its start state
    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        tok_take && (q_token.cls == htbd_pkg::CLS_END) |=> status.at_start)
        else $error("parser not at start after end of text");

    // Back end never writes a full result queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result queue overflow");

    // A byte comes out only when a first digit was held
    a_byte_needs_high: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && (res_in.kind == htbd_pkg::KIND_BYTE) |-> status.have_high)
        else $error("byte emitted without first digit");

    // An error result only when a first digit was held
    a_error_needs_high: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && (res_in.kind == htbd_pkg::KIND_ERROR) |-> status.have_high)
        else $error("error emitted without first digit");

endmodule

// ===== sv/htbd_fifo.sv =====
// Small first-in first-out queue of register slots, generic payload width.
// No dependencies; instantiated twice by the top level.
module htbd_fifo #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] data_in,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] data_out
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = slot_reg[rd_ptr_reg];

    // Pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= data_in;
        end
    end

endmodule

// ===== sv/htbd_front.sv =====
// Front end: holds the underscore option and classifies each input transfer.
// Depends on htbd_pkg.
module htbd_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write_en,
    input  logic            cfg_write_data,
    input  logic            op,
    input  logic [7:0]      char_code,
    output htbd_pkg::token_t token
);

    logic allow_underscore_reg;

    // Option register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_underscore_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            allow_underscore_reg <= cfg_write_data;
        end
    end

    // Character classifier; letters map to low nibble + 9
    always_comb
    begin
        token.cls   = htbd_pkg::CLS_OTHER;
        token.digit = 4'd0;
        if (op == htbd_pkg::OP_END)
        begin
            token.cls = htbd_pkg::CLS_END;
        end
        else
        begin
            unique case (char_code) inside
                [8'h30:8'h39]:
                begin
                    token.cls   = htbd_pkg::CLS_DIGIT;
                    token.digit = char_code[3:0];
                end
                [8'h41:8'h46], [8'h61:8'h66]:
                begin
                    token.cls   = htbd_pkg::CLS_DIGIT;
                    token.digit = char_code[3:0] + 4'd9;
                end
                htbd_pkg::CHAR_LF, htbd_pkg::CHAR_CR:
                begin
                    token.cls = htbd_pkg::CLS_EOL;
                end
                htbd_pkg::CHAR_SPACE, htbd_pkg::CHAR_TAB, htbd_pkg::CHAR_VT,
                htbd_pkg::CHAR_FF:
                begin
                    token.cls = htbd_pkg::CLS_SPACE;
                end
                htbd_pkg::CHAR_SLASH:
                begin
                    token.cls = htbd_pkg::CLS_SLASH;
                end
                htbd_pkg::CHAR_STAR:
                begin
                    token.cls = htbd_pkg::CLS_STAR;
                end
                htbd_pkg::CHAR_UNDERSCORE:
                begin
                    token.cls = allow_underscore_reg ? htbd_pkg::CLS_DIGIT
                                                     : htbd_pkg::CLS_OTHER;
                end
                default:
                begin
                    token.cls = htbd_pkg::CLS_OTHER;
                end
            endcase
        end
    end

endmodule

// ===== sv/htbd_back.sv =====
// Back end: comment-skip state machine and digit pairing, one token per cycle while the result queue is not full.
// Depends on htbd_pkg.
module htbd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_valid,
    input  htbd_pkg::token_t  tok,
    output logic              tok_take,
    input  logic              res_full,
    output logic              res_push,
    output htbd_pkg::result_t res,
    output htbd_pkg::status_t status
);

    typedef enum logic [4:0] {
        MODE_TEXT       = 5'b00001,
        MODE_SLASH      = 5'b00010,
        MODE_LINE       = 5'b00100,
        MODE_BLOCK      = 5'b01000,
        MODE_BLOCK_STAR = 5'b10000
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic       have_high_reg, have_high_next;
    logic [3:0] high_digit_reg, high_digit_next;
    logic       emit;
    logic       finish;

    assign tok_take = tok_valid && !res_full;
    assign res_push = tok_take && emit;

    assign status.at_start  = (mode_reg == MODE_TEXT) && !have_high_reg;
    assign status.have_high = have_high_reg;

    // Next state and result
    always_comb
    begin
        mode_next       = mode_reg;
        have_high_next  = have_high_reg;
        high_digit_next = high_digit_reg;
        emit            = 1'b0;
        finish          = 1'b0;
        res.kind        = htbd_pkg::KIND_BYTE;
        res.data        = {high_digit_reg, tok.digit};

        if (tok_take)
        begin
            if (tok.cls == htbd_pkg::CLS_END)
            begin
                finish = 1'b1;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_SLASH:
                    begin
                        if (tok.cls == htbd_pkg::CLS_SLASH)
                            mode_next = MODE_LINE;
                        else if (tok.cls == htbd_pkg::CLS_STAR)
                            mode_next = MODE_BLOCK;
                        else
                            finish = 1'b1;
                    end
                    MODE_LINE:
                    begin
                        if (tok.cls == htbd_pkg::CLS_EOL)
                            mode_next = MODE_TEXT;
                    end
                    MODE_BLOCK:
                    begin
                        if (tok.cls == htbd_pkg::CLS_STAR)
                            mode_next = MODE_BLOCK_STAR;
                    end
                    MODE_BLOCK_STAR:
                    begin
                        if (tok.cls == htbd_pkg::CLS_SLASH)
                            mode_next = MODE_TEXT;
                        else if (tok.cls != htbd_pkg::CLS_STAR)
                            mode_next = MODE_BLOCK;
                    end
                    MODE_TEXT:
                    begin
                        case (tok.cls)
                            htbd_pkg::CLS_SPACE, htbd_pkg::CLS_EOL:
                            begin
                                // whitespace skipped
                            end
                            htbd_pkg::CLS_SLASH:
                            begin
                                mode_next = MODE_SLASH;
                            end
                            htbd_pkg::CLS_DIGIT:
                            begin
                                if (have_high_reg)
                                begin
                                    emit            = 1'b1;
                                    have_high_next  = 1'b0;
                                    high_digit_next = 4'd0;
                                end
                                else
                                begin
                                    have_high_next  = 1'b1;
                                    high_digit_next = tok.digit;
                                end
                            end
                            default:
                            begin
                                finish = 1'b1;
                            end
                        endcase
                    end
                    default:
                    begin
                        mode_next = MODE_TEXT;
                    end
                endcase
            end

            // Stop or error: back to start state
            if (finish)
            begin
                emit            = 1'b1;
                res.kind        = have_high_reg ? htbd_pkg::KIND_ERROR
                                                : htbd_pkg::KIND_STOP;
                res.data        = 8'd0;
                mode_next       = MODE_TEXT;
                have_high_next  = 1'b0;
                high_digit_next = 4'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_TEXT;
            have_high_reg  <= 1'b0;
            high_digit_reg <= 4'd0;
        end
        else
        begin
            mode_reg       <= mode_next;
            have_high_reg  <= have_high_next;
            high_digit_reg <= high_digit_next;
        end
    end

endmodule
